### rtl/core/tipd_pkg.sv
// ----------------------------------------------------------------------------
// Thumb predecoder package
// Word types, mnemonic codes and field constants shared by the predecoder.
// ----------------------------------------------------------------------------
package tipd_pkg;

    typedef struct packed {
        logic [15:0] halfword;
        logic        last;
    } instr_t;

    typedef struct packed {
        logic [31:0] address;
        logic        is_wide;
        logic [5:0]  mnemonic;
        logic [3:0]  cond;
        logic [3:0]  reg_a;
        logic [3:0]  reg_b;
        logic [3:0]  reg_c;
        logic [31:0] immediate;
        logic [31:0] target;
        logic        branch_flag;
        logic        is_call;
        logic [2:0]  ref_kind;
    } record_t;

    typedef struct packed {
        logic [31:0] address;
        logic        is_wide;
        logic [15:0] first;
        logic [15:0] second;
    } pair_t;

    localparam logic [5:0] MN_BL    = 6'd0;
    localparam logic [5:0] MN_BLX   = 6'd1;
    localparam logic [5:0] MN_MOVW  = 6'd2;
    localparam logic [5:0] MN_MOVT  = 6'd3;
    localparam logic [5:0] MN_LDR_W = 6'd4;
    localparam logic [5:0] MN_STR_W = 6'd5;
    localparam logic [5:0] MN_B_W   = 6'd6;
    localparam logic [5:0] MN_DCD_W = 6'd7;
    localparam logic [5:0] MN_LSLS  = 6'd8;
    localparam logic [5:0] MN_ADDS  = 6'd11;
    localparam logic [5:0] MN_SUBS  = 6'd12;
    localparam logic [5:0] MN_MOVS  = 6'd13;
    localparam logic [5:0] MN_CMP   = 6'd14;
    localparam logic [5:0] MN_LDR   = 6'd15;
    localparam logic [5:0] MN_STR   = 6'd16;
    localparam logic [5:0] MN_STRH  = 6'd17;
    localparam logic [5:0] MN_STRB  = 6'd18;
    localparam logic [5:0] MN_LDRSB = 6'd19;
    localparam logic [5:0] MN_LDRH  = 6'd20;
    localparam logic [5:0] MN_LDRB  = 6'd21;
    localparam logic [5:0] MN_LDRSH = 6'd22;
    localparam logic [5:0] MN_PUSH  = 6'd23;
    localparam logic [5:0] MN_POP   = 6'd24;
    localparam logic [5:0] MN_B     = 6'd25;
    localparam logic [5:0] MN_BX    = 6'd26;
    localparam logic [5:0] MN_ADD   = 6'd27;
    localparam logic [5:0] MN_MOV   = 6'd28;
    localparam logic [5:0] MN_SUB   = 6'd29;
    localparam logic [5:0] MN_SVC   = 6'd30;
    localparam logic [5:0] MN_NOP   = 6'd31;
    localparam logic [5:0] MN_DCW   = 6'd32;

    localparam logic [3:0] COND_ALWAYS = 4'd14;
    localparam logic [3:0] REG_SP      = 4'd13;
    localparam logic [3:0] REG_LR      = 4'd14;
    localparam logic [3:0] REG_PC      = 4'd15;

    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_BRANCH = 3'd1;
    localparam logic [2:0] KIND_CALL   = 3'd2;
    localparam logic [2:0] KIND_DATA   = 3'd3;
    localparam logic [2:0] KIND_RETURN = 3'd4;

    localparam logic [4:0] PREFIX_MIN = 5'h1D;

endpackage

### rtl/core/thumb_instruction_predecoder.sv
// ----------------------------------------------------------------------------
// Thumb instruction predecoder
// Turns a stream of Thumb halfwords into one decoded record per instruction.
// ----------------------------------------------------------------------------
// Halfwords are taken one per cycle whenever full is low. A narrow
// instruction's halfword is first written into the instruction queue, and
// the decoder then writes its record into the output register that drives
// the result ports. The first half of a wide instruction gives no record;
// the record follows its second half along the same path. The sustained
// rate is one halfword per cycle while results are popped, set by the
// single-entry decode stage; full rises only after the queue of
// QUEUE_DEPTH entries has filled behind a stalled result.
module thumb_instruction_predecoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              base_address_we,
    input  logic [31:0]       base_address,
    input  logic              push,
    output logic              full,
    input  tipd_pkg::instr_t  instr,
    output logic              empty,
    input  logic              pop,
    output tipd_pkg::record_t record
);
    import tipd_pkg::*;

    logic [31:0] base_address_reg;
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_empty;
    pair_t       q_wr_data;
    pair_t       q_rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_address_reg <= '0;
        end
        else if (base_address_we)
        begin
            base_address_reg <= base_address;
        end
    end

    tipd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .base_address (base_address_reg),
        .push         (push),
        .full         (full),
        .instr        (instr),
        .q_push       (q_push),
        .q_full       (q_full),
        .q_data       (q_wr_data)
    );

    tipd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .q_empty (q_empty),
        .rd_data (q_rd_data)
    );

    tipd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .q_data  (q_rd_data),
        .empty   (empty),
        .pop     (pop),
        .record  (record)
    );

endmodule

### rtl/core/tipd_front.sv
// ----------------------------------------------------------------------------
// Thumb predecoder front end
// Accepts halfwords, pairs wide prefixes and tags each instruction with its
// address.
// ----------------------------------------------------------------------------
module tipd_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [31:0]      base_address,
    input  logic             push,
    output logic             full,
    input  tipd_pkg::instr_t instr,
    output logic             q_push,
    input  logic             q_full,
    output tipd_pkg::pair_t  q_data
);
    import tipd_pkg::*;

    logic        held_valid_reg;
    logic        held_valid_next;
    logic [15:0] held_halfword_reg;
    logic [15:0] held_halfword_next;
    logic [31:0] byte_offset_reg;
    logic [31:0] byte_offset_next;
    logic        accept;
    logic        is_prefix;

    assign full      = q_full;
    assign accept    = push && !q_full;
    assign is_prefix = instr.halfword[15:11] >= PREFIX_MIN;

    assign q_data.address = base_address + byte_offset_reg;
    assign q_data.is_wide = held_valid_reg;
    assign q_data.first   = held_valid_reg ? held_halfword_reg : instr.halfword;
    assign q_data.second  = instr.halfword;
    assign q_push = accept && (held_valid_reg || !is_prefix || instr.last);

    always_comb
    begin
        held_valid_next    = held_valid_reg;
        held_halfword_next = held_halfword_reg;
        byte_offset_next   = byte_offset_reg;
        if (accept)
        begin
            if (held_valid_reg)
            begin
                held_valid_next  = 1'b0;
                byte_offset_next = byte_offset_reg + 32'd4;
            end
            else if (is_prefix && !instr.last)
            begin
                held_valid_next    = 1'b1;
                held_halfword_next = instr.halfword;
            end
            else
            begin
                byte_offset_next = byte_offset_reg + 32'd2;
            end
            if (instr.last)
            begin
                held_valid_next  = 1'b0;
                byte_offset_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg    <= 1'b0;
            held_halfword_reg <= '0;
            byte_offset_reg   <= '0;
        end
        else
        begin
            held_valid_reg    <= held_valid_next;
            held_halfword_reg <= held_halfword_next;
            byte_offset_reg   <= byte_offset_next;
        end
    end

endmodule

### rtl/core/tipd_queue.sv
// ----------------------------------------------------------------------------
// Thumb predecoder instruction queue
// Small first-in first-out buffer between the front end and the decoder.
// ----------------------------------------------------------------------------
module tipd_queue #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  tipd_pkg::pair_t wr_data,
    output logic            q_full,
    input  logic            rd_en,
    output logic            q_empty,
    output tipd_pkg::pair_t rd_data
);
    import tipd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pair_t           entry_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_wr;
    logic            do_rd;

    assign q_full  = count_reg == CW'(DEPTH);
    assign q_empty = count_reg == '0;
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/core/tipd_back.sv
// ----------------------------------------------------------------------------
// Thumb predecoder back end
// Decodes a queued instruction per unstalled cycle into the registered record.
// ----------------------------------------------------------------------------
module tipd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    output logic              q_pop,
    input  tipd_pkg::pair_t   q_data,
    output logic              empty,
    input  logic              pop,
    output tipd_pkg::record_t record
);
    import tipd_pkg::*;

    logic        out_valid_reg;
    logic        out_valid_next;
    record_t     record_reg;
    record_t     dec;
    logic [15:0] h1;
    logic [15:0] h2;
    logic [15:0] h;
    logic [31:0] addr;
    logic [31:0] pc;
    logic [31:0] pc_aligned;
    logic        s;
    logic [31:0] off_bl;
    logic [31:0] off_bw;
    logic [31:0] off_bcond;
    logic [31:0] off_b;
    logic [31:0] lit_imm;

    assign h1         = q_data.first;
    assign h2         = q_data.second;
    assign h          = q_data.first;
    assign addr       = q_data.address;
    assign pc         = addr + 32'd4;
    assign pc_aligned = {pc[31:2], 2'b00};
    assign s          = h1[10];
    assign off_bl     = {{7{s}}, s, ~(h2[13] ^ s), ~(h2[11] ^ s), h1[9:0], h2[10:0], 1'b0};
    assign off_bw     = {{11{s}}, s, h2[11], h2[13], h1[5:0], h2[10:0], 1'b0};
    assign off_bcond  = {{23{h[7]}}, h[7:0], 1'b0};
    assign off_b      = {{20{h[10]}}, h[10:0], 1'b0};
    assign lit_imm    = {22'd0, h[7:0], 2'b00};

    always_comb
    begin
        dec           = '0;
        dec.address   = addr;
        dec.is_wide   = q_data.is_wide;
        dec.cond      = COND_ALWAYS;
        if (q_data.is_wide)
        begin
            if (h1[15:11] == 5'h1E && h2[15:14] == 2'b11)
            begin
                dec.mnemonic  = h2[12] ? MN_BL : MN_BLX;
                dec.immediate = off_bl;
                dec.target    = (h2[12] ? pc : pc_aligned) + off_bl;
                dec.is_call   = 1'b1;
                dec.ref_kind  = KIND_CALL;
            end
            else if ((h1 & 16'hFBF0) == 16'hF240 || (h1 & 16'hFBF0) == 16'hF2C0)
            begin
                dec.mnemonic  = ((h1 & 16'hFBF0) == 16'hF2C0) ? MN_MOVT : MN_MOVW;
                dec.reg_a     = h2[11:8];
                dec.immediate = {16'd0, h1[3:0], h1[10], h2[14:12], h2[7:0]};
            end
            else if (h1[15:4] == 12'hF8D || h1[15:4] == 12'hF8C)
            begin
                dec.mnemonic  = h1[4] ? MN_LDR_W : MN_STR_W;
                dec.reg_a     = h2[15:12];
                dec.reg_b     = h1[3:0];
                dec.immediate = {20'd0, h2[11:0]};
            end
            else if (h1[15:11] == 5'h1E && h2[15] && !h2[14] && !h2[12])
            begin
                dec.mnemonic    = MN_B_W;
                dec.cond        = h1[9:6];
                dec.immediate   = off_bw;
                dec.target      = pc + off_bw;
                dec.branch_flag = 1'b1;
                dec.ref_kind    = KIND_BRANCH;
            end
            else
            begin
                dec.mnemonic  = MN_DCD_W;
                dec.immediate = {h1, h2};
            end
        end
        else
        begin
            dec.mnemonic  = MN_DCW;
            dec.immediate = {16'd0, h};
            if (h[15:11] == 5'h03)
            begin
                dec.mnemonic = h[9] ? MN_SUBS : MN_ADDS;
                dec.reg_a    = {1'b0, h[2:0]};
                dec.reg_b    = {1'b0, h[5:3]};
                if (!h[10])
                begin
                    dec.reg_c     = {1'b0, h[8:6]};
                    dec.immediate = '0;
                end
                else
                begin
                    dec.immediate = {29'd0, h[8:6]};
                end
            end
            else if (h[15:13] == 3'd0)
            begin
                dec.mnemonic  = MN_LSLS + {4'd0, h[12:11]};
                dec.reg_a     = {1'b0, h[2:0]};
                dec.reg_b     = {1'b0, h[5:3]};
                dec.immediate = {27'd0, h[10:6]};
            end
            else if (h[15:13] == 3'd1)
            begin
                case (h[12:11])
                    2'd0:    dec.mnemonic = MN_MOVS;
                    2'd1:    dec.mnemonic = MN_CMP;
                    2'd2:    dec.mnemonic = MN_ADDS;
                    default: dec.mnemonic = MN_SUBS;
                endcase
                dec.reg_a     = {1'b0, h[10:8]};
                dec.immediate = {24'd0, h[7:0]};
            end
            else if (h[15:11] == 5'h09)
            begin
                dec.mnemonic  = MN_LDR;
                dec.reg_a     = {1'b0, h[10:8]};
                dec.reg_b     = REG_PC;
                dec.immediate = lit_imm;
                dec.target    = pc_aligned + lit_imm;
                dec.ref_kind  = KIND_DATA;
            end
            else if (h[15:12] == 4'h5)
            begin
                case (h[11:9])
                    3'd0:    dec.mnemonic = MN_STR;
                    3'd1:    dec.mnemonic = MN_STRH;
                    3'd2:    dec.mnemonic = MN_STRB;
                    3'd3:    dec.mnemonic = MN_LDRSB;
                    3'd4:    dec.mnemonic = MN_LDR;
                    3'd5:    dec.mnemonic = MN_LDRH;
                    3'd6:    dec.mnemonic = MN_LDRB;
                    default: dec.mnemonic = MN_LDRSH;
                endcase
                dec.reg_a     = {1'b0, h[2:0]};
                dec.reg_b     = {1'b0, h[5:3]};
                dec.reg_c     = {1'b0, h[8:6]};
                dec.immediate = '0;
            end
            else if (h[15:13] == 3'd3)
            begin
                if (h[12])
                begin
                    dec.mnemonic  = h[11] ? MN_LDRB : MN_STRB;
                    dec.immediate = {27'd0, h[10:6]};
                end
                else
                begin
                    dec.mnemonic  = h[11] ? MN_LDR : MN_STR;
                    dec.immediate = {25'd0, h[10:6], 2'b00};
                end
                dec.reg_a = {1'b0, h[2:0]};
                dec.reg_b = {1'b0, h[5:3]};
            end
            else if ((h & 16'hFE00) == 16'hB400)
            begin
                dec.mnemonic  = MN_PUSH;
                dec.immediate = {17'd0, h[8], 6'd0, h[7:0]};
            end
            else if ((h & 16'hFE00) == 16'hBC00)
            begin
                dec.mnemonic  = MN_POP;
                dec.immediate = {16'd0, h[8], 7'd0, h[7:0]};
                dec.ref_kind  = h[8] ? KIND_RETURN : KIND_NONE;
            end
            else if (h[15:12] == 4'hD && h[11:8] < 4'hE)
            begin
                dec.mnemonic    = MN_B;
                dec.cond        = h[11:8];
                dec.immediate   = off_bcond;
                dec.target      = pc + off_bcond;
                dec.branch_flag = 1'b1;
                dec.ref_kind    = KIND_BRANCH;
            end
            else if (h[15:11] == 5'h1C)
            begin
                dec.mnemonic    = MN_B;
                dec.immediate   = off_b;
                dec.target      = pc + off_b;
                dec.branch_flag = 1'b1;
                dec.ref_kind    = KIND_BRANCH;
            end
            else if (h[15:8] == 8'h47)
            begin
                dec.mnemonic  = h[7] ? MN_BLX : MN_BX;
                dec.reg_b     = h[6:3];
                dec.immediate = '0;
                dec.is_call   = h[7];
                dec.ref_kind  = (!h[7] && h[6:3] == REG_LR) ? KIND_RETURN : KIND_NONE;
            end
            else if (h[15:10] == 6'b010001)
            begin
                case (h[9:8])
                    2'd0:    dec.mnemonic = MN_ADD;
                    2'd1:    dec.mnemonic = MN_CMP;
                    default: dec.mnemonic = MN_MOV;
                endcase
                dec.reg_a     = {h[7], h[2:0]};
                dec.reg_b     = h[6:3];
                dec.immediate = '0;
            end
            else if (h[15:8] == 8'hB0)
            begin
                dec.mnemonic  = h[7] ? MN_SUB : MN_ADD;
                dec.reg_a     = REG_SP;
                dec.immediate = {23'd0, h[6:0], 2'b00};
            end
            else if (h[15:8] == 8'hDF)
            begin
                dec.mnemonic  = MN_SVC;
                dec.immediate = {24'd0, h[7:0]};
            end
            else if (h == 16'hBF00)
            begin
                dec.mnemonic  = MN_NOP;
                dec.immediate = '0;
            end
        end
    end

    assign q_pop  = !q_empty && (!out_valid_reg || pop);
    assign empty  = !out_valid_reg;
    assign record = record_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (q_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            record_reg <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // A wide record only ever carries one of the 32-bit mnemonics.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && record_reg.is_wide) |-> (record_reg.mnemonic <= MN_DCD_W))
        else $error("wide record with a narrow mnemonic");

    // Branch records always point their reference at a branch target.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && record_reg.branch_flag) |-> (record_reg.ref_kind == KIND_BRANCH))
        else $error("branch record without branch reference");

    // A held result must not be overwritten while the consumer stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> (out_valid_reg && $stable(record_reg)))
        else $error("output record changed while stalled");

endmodule

### sim/thumb_instruction_predecoder_tb.sv
// ----------------------------------------------------------------------------
// Thumb instruction predecoder testbench
// Streams Thumb halfwords into the predecoder under random input gaps and
// output stalls, predicts each decoded record, and compares every record
// field by field in arrival order.
// ----------------------------------------------------------------------------
module thumb_instruction_predecoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tipd_pkg::*;

    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 50;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASES        = 4;
    localparam int PHASE_WORDS   = 180;

    // Directed halfwords, written as {last, halfword}.
    localparam logic [16:0] DIRECTED [27] = '{
        17'h00000, 17'h01888, 17'h04BFF, 17'h0B5FF, 17'h0BDFF, 17'h0D080,
        17'h0DE00, 17'h0E400, 17'h04770, 17'h04798, 17'h0B0FF, 17'h0BF00,
        17'h0F7FF, 17'h0FFFE, 17'h0F000, 17'h0E800, 17'h0F64F, 17'h07FFF,
        17'h0F8D1, 17'h02004, 17'h0F43F, 17'h0AFFE, 17'h0FFFF, 17'h0FFFF,
        17'h1F000, 17'h0F780, 17'h18000
    };

    class predecode_scoreboard;
        logic [31:0] img_base;
        bit          prefix_valid;
        logic [15:0] prefix_hw;
        logic [31:0] next_offset;
        record_t     expected_records [$];
        int          errors;

        function new();
            img_base     = 32'd0;
            prefix_valid = 1'b0;
            prefix_hw    = 16'd0;
            next_offset  = 32'd0;
            errors       = 0;
        endfunction

        function void set_base(logic [31:0] value);
            img_base = value;
        endfunction

        function int pending();
            return expected_records.size();
        endfunction

        function record_t blank(logic [31:0] addr, logic wide);
            record_t r;
            r = '0;
            r.address = addr;
            r.is_wide = wide;
            r.cond = COND_ALWAYS;
            return r;
        endfunction

        function record_t decode_pair(logic [15:0] h1, logic [15:0] h2, logic [31:0] addr);
            record_t r;
            logic s;
            logic j1;
            logic j2;
            logic [31:0] off;
            r = blank(addr, 1'b1);
            if (h1[15:11] == 5'b11110 && h2[15:14] == 2'b11)
            begin
                s = h1[10];
                j1 = ~(h2[13] ^ s);
                j2 = ~(h2[11] ^ s);
                off = {{8{s}}, j1, j2, h1[9:0], h2[10:0], 1'b0};
                r.mnemonic = h2[12] ? MN_BL : MN_BLX;
                r.immediate = off;
                r.target = (h2[12] ? addr + 32'd4 : ((addr + 32'd4) & ~32'd3)) + off;
                r.is_call = 1'b1;
                r.ref_kind = KIND_CALL;
            end
            else if ((h1 & 16'hFBF0) == 16'hF240 || (h1 & 16'hFBF0) == 16'hF2C0)
            begin
                r.mnemonic = ((h1 & 16'hFBF0) == 16'hF2C0) ? MN_MOVT : MN_MOVW;
                r.reg_a = h2[11:8];
                r.immediate = {16'd0, h1[3:0], h1[10], h2[14:12], h2[7:0]};
            end
            else if ((h1 & 16'hFFF0) == 16'hF8D0 || (h1 & 16'hFFF0) == 16'hF8C0)
            begin
                r.mnemonic = ((h1 & 16'hFFF0) == 16'hF8D0) ? MN_LDR_W : MN_STR_W;
                r.reg_a = h2[15:12];
                r.reg_b = h1[3:0];
                r.immediate = {20'd0, h2[11:0]};
            end
            else if (h1[15:11] == 5'b11110 && (h2 & 16'hD000) == 16'h8000)
            begin
                s = h1[10];
                off = {{12{s}}, h2[11], h2[13], h1[5:0], h2[10:0], 1'b0};
                r.mnemonic = MN_B_W;
                r.cond = h1[9:6];
                r.immediate = off;
                r.target = addr + 32'd4 + off;
                r.branch_flag = 1'b1;
                r.ref_kind = KIND_BRANCH;
            end
            else
            begin
                r.mnemonic = MN_DCD_W;
                r.immediate = {h1, h2};
            end
            return r;
        endfunction

        function record_t decode_single(logic [15:0] h, logic [31:0] addr);
            record_t r;
            logic [31:0] off;
            r = blank(addr, 1'b0);
            r.mnemonic = MN_DCW;
            r.immediate = {16'd0, h};
            if (h[15:11] == 5'd3)
            begin
                r.mnemonic = h[9] ? MN_SUBS : MN_ADDS;
                r.reg_a = {1'b0, h[2:0]};
                r.reg_b = {1'b0, h[5:3]};
                if (!h[10])
                begin
                    r.reg_c = {1'b0, h[8:6]};
                    r.immediate = 32'd0;
                end
                else
                    r.immediate = {29'd0, h[8:6]};
            end
            else if (h[15:13] == 3'd0)
            begin
                r.mnemonic = MN_LSLS + {4'd0, h[12:11]};
                r.reg_a = {1'b0, h[2:0]};
                r.reg_b = {1'b0, h[5:3]};
                r.immediate = {27'd0, h[10:6]};
            end
            else if (h[15:13] == 3'd1)
            begin
                case (h[12:11])
                    2'd0: r.mnemonic = MN_MOVS;
                    2'd1: r.mnemonic = MN_CMP;
                    2'd2: r.mnemonic = MN_ADDS;
                    default: r.mnemonic = MN_SUBS;
                endcase
                r.reg_a = {1'b0, h[10:8]};
                r.immediate = {24'd0, h[7:0]};
            end
            else if (h[15:11] == 5'd9)
            begin
                r.mnemonic = MN_LDR;
                r.reg_a = {1'b0, h[10:8]};
                r.reg_b = REG_PC;
                r.immediate = {22'd0, h[7:0], 2'b00};
                r.target = ((addr + 32'd4) & ~32'd3) + r.immediate;
                r.ref_kind = KIND_DATA;
            end
            else if (h[15:12] == 4'd5)
            begin
                case (h[11:9])
                    3'd0: r.mnemonic = MN_STR;
                    3'd1: r.mnemonic = MN_STRH;
                    3'd2: r.mnemonic = MN_STRB;
                    3'd3: r.mnemonic = MN_LDRSB;
                    3'd4: r.mnemonic = MN_LDR;
                    3'd5: r.mnemonic = MN_LDRH;
                    3'd6: r.mnemonic = MN_LDRB;
                    default: r.mnemonic = MN_LDRSH;
                endcase
                r.reg_a = {1'b0, h[2:0]};
                r.reg_b = {1'b0, h[5:3]};
                r.reg_c = {1'b0, h[8:6]};
                r.immediate = 32'd0;
            end
            else if (h[15:13] == 3'd3)
            begin
                if (h[12])
                begin
                    r.mnemonic = h[11] ? MN_LDRB : MN_STRB;
                    r.immediate = {27'd0, h[10:6]};
                end
                else
                begin
                    r.mnemonic = h[11] ? MN_LDR : MN_STR;
                    r.immediate = {25'd0, h[10:6], 2'b00};
                end
                r.reg_a = {1'b0, h[2:0]};
                r.reg_b = {1'b0, h[5:3]};
            end
            else if ((h & 16'hFE00) == 16'hB400)
            begin
                r.mnemonic = MN_PUSH;
                r.immediate = {17'd0, h[8], 6'd0, h[7:0]};
            end
            else if ((h & 16'hFE00) == 16'hBC00)
            begin
                r.mnemonic = MN_POP;
                r.immediate = {16'd0, h[8], 7'd0, h[7:0]};
                if (h[8])
                    r.ref_kind = KIND_RETURN;
            end
            else if (h[15:12] == 4'hD && h[11:8] < 4'hE)
            begin
                off = {{23{h[7]}}, h[7:0], 1'b0};
                r.mnemonic = MN_B;
                r.cond = h[11:8];
                r.immediate = off;
                r.target = addr + 32'd4 + off;
                r.branch_flag = 1'b1;
                r.ref_kind = KIND_BRANCH;
            end
            else if (h[15:11] == 5'h1C)
            begin
                off = {{20{h[10]}}, h[10:0], 1'b0};
                r.mnemonic = MN_B;
                r.immediate = off;
                r.target = addr + 32'd4 + off;
                r.branch_flag = 1'b1;
                r.ref_kind = KIND_BRANCH;
            end
            else if (h[15:8] == 8'h47)
            begin
                r.mnemonic = h[7] ? MN_BLX : MN_BX;
                r.reg_b = h[6:3];
                r.immediate = 32'd0;
                if (h[7])
                    r.is_call = 1'b1;
                else if (h[6:3] == REG_LR)
                    r.ref_kind = KIND_RETURN;
            end
            else if (h[15:10] == 6'b010001)
            begin
                case (h[9:8])
                    2'd0: r.mnemonic = MN_ADD;
                    2'd1: r.mnemonic = MN_CMP;
                    default: r.mnemonic = MN_MOV;
                endcase
                r.reg_a = {h[7], h[2:0]};
                r.reg_b = h[6:3];
                r.immediate = 32'd0;
            end
            else if (h[15:8] == 8'hB0)
            begin
                r.mnemonic = h[7] ? MN_SUB : MN_ADD;
                r.reg_a = REG_SP;
                r.immediate = {23'd0, h[6:0], 2'b00};
            end
            else if (h[15:8] == 8'hDF)
            begin
                r.mnemonic = MN_SVC;
                r.immediate = {24'd0, h[7:0]};
            end
            else if (h == 16'hBF00)
            begin
                r.mnemonic = MN_NOP;
                r.immediate = 32'd0;
            end
            return r;
        endfunction

        function void note_word(instr_t w);
            logic [31:0] addr;
            addr = img_base + next_offset;
            if (prefix_valid)
            begin
                expected_records = {expected_records,
                                    decode_pair(prefix_hw, w.halfword, addr)};
                prefix_valid = 1'b0;
                prefix_hw = 16'd0;
                next_offset = next_offset + 32'd4;
            end
            else if (w.halfword[15:11] >= PREFIX_MIN && !w.last)
            begin
                prefix_valid = 1'b1;
                prefix_hw = w.halfword;
            end
            else
            begin
                expected_records = {expected_records, decode_single(w.halfword, addr)};
                next_offset = next_offset + 32'd2;
            end
            if (w.last)
            begin
                prefix_valid = 1'b0;
                prefix_hw = 16'd0;
                next_offset = 32'd0;
            end
        endfunction

        function string show(record_t r);
            return $sformatf({"addr=%h wide=%0d mn=%0d cond=%0d a=%0d b=%0d c=%0d ",
                              "imm=%h tgt=%h br=%0d call=%0d kind=%0d"},
                             r.address, r.is_wide, r.mnemonic, r.cond, r.reg_a,
                             r.reg_b, r.reg_c, r.immediate, r.target, r.branch_flag,
                             r.is_call, r.ref_kind);
        endfunction

        function void report(string what, string detail);
            errors++;
            if (errors <= 10)
                $display("%0t %s: %s", $time, what, detail);
        endfunction

        function void check_word(record_t got);
            record_t exp;
            if (expected_records.size() == 0)
            begin
                report("unexpected record", show(got));
                return;
            end
            exp = expected_records.pop_front();
            if (got.address !== exp.address || got.is_wide !== exp.is_wide ||
                got.mnemonic !== exp.mnemonic || got.cond !== exp.cond ||
                got.reg_a !== exp.reg_a || got.reg_b !== exp.reg_b ||
                got.reg_c !== exp.reg_c || got.immediate !== exp.immediate ||
                got.target !== exp.target || got.branch_flag !== exp.branch_flag ||
                got.is_call !== exp.is_call || got.ref_kind !== exp.ref_kind)
                report("record mismatch",
                       {"expected ", show(exp), " actual ", show(got)});
        endfunction

        function void flush_missing();
            while (expected_records.size() != 0)
                report("missing record", show(expected_records.pop_front()));
        endfunction
    endclass

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    base_we = 1'b0;
    logic [31:0] base_value = 32'd0;
    logic    push = 1'b0;
    logic    full;
    instr_t  instr_word = '0;
    logic    empty;
    logic    pop = 1'b0;
    record_t rec_out;

    predecode_scoreboard sb;
    int      send_calm;
    bit      hold_pop;

    thumb_instruction_predecoder dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .base_address_we (base_we),
        .base_address    (base_value),
        .push            (push),
        .full            (full),
        .instr           (instr_word),
        .empty           (empty),
        .pop             (pop),
        .record          (rec_out)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [15:0] rand_narrow();
        logic [15:0] r;
        r = 16'($urandom);
        case ($urandom_range(0, 11))
            0: return 16'h4700 | (r & 16'h00FF);
            1: return 16'hB400 | (r & 16'h09FF);
            2: return 16'hD000 | (r & 16'h0FFF);
            3: return 16'hB000 | (r & 16'h0FFF);
            4: return r[0] ? 16'hBF00 : (16'hDF00 | (r & 16'h00FF));
            5: return 16'h4400 | (r & 16'h03FF);
            6: return 16'h4800 | (r & 16'h07FF);
            default: return 16'($urandom_range(0, 32'hE7FF));
        endcase
    endfunction

    task automatic rand_pair(output logic [15:0] h1, output logic [15:0] h2);
        logic [15:0] r1;
        logic [15:0] r2;
        r1 = 16'($urandom);
        r2 = 16'($urandom);
        case ($urandom_range(0, 5))
            0:
            begin
                h1 = 16'hF000 | (r1 & 16'h07FF);
                h2 = 16'hC000 | (r2 & 16'h3FFF);
            end
            1:
            begin
                h1 = 16'hF240 | (r1 & 16'h048F);
                h2 = r2;
            end
            2:
            begin
                h1 = 16'hF8C0 | (r1 & 16'h001F);
                h2 = r2;
            end
            3:
            begin
                h1 = 16'hF000 | (r1 & 16'h07FF);
                h2 = 16'h8000 | (r2 & 16'h2FFF);
            end
            default:
            begin
                h1 = {5'($urandom_range(29, 31)), r1[10:0]};
                h2 = r2;
            end
        endcase
    endtask

    task automatic send_word(input logic [15:0] hw, input logic last_flag, input bit no_gap);
        instr_t w;
        int gap;
        w.halfword = hw;
        w.last = last_flag;
        push <= 1'b1;
        instr_word <= w;
        do
            @(posedge clk);
        while (full);
        sb.note_word(w);
        gap = no_gap ? 0 : pick_gap(send_calm);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_and_settle();
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_base(input logic [31:0] value);
        base_we <= 1'b1;
        base_value <= value;
        @(posedge clk);
        base_we <= 1'b0;
        sb.set_base(value);
    endtask

    task automatic random_words(input int count);
        int sent;
        int r;
        logic [15:0] h1;
        logic [15:0] h2;
        sent = 0;
        while (sent < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 2)
            begin
                send_word({5'($urandom_range(29, 31)), 11'($urandom)}, 1'b1, 1'b0);
                sent++;
            end
            else if (r < 32)
            begin
                rand_pair(h1, h2);
                send_word(h1, 1'b0, 1'b0);
                send_word(h2, ($urandom_range(0, 99) < 4), 1'b0);
                sent += 2;
            end
            else
            begin
                send_word(rand_narrow(), ($urandom_range(0, 99) < 3), 1'b0);
                sent++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_word(rec_out);
    end

    initial
    begin
        int idle_left;
        int calm;
        idle_left = 0;
        calm = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_pop)
            begin
                hold_pop = 1'b0;
                idle_left = HOLD_CYCLES;
            end
            if (idle_left > 0)
            begin
                pop <= 1'b0;
                idle_left--;
            end
            else
            begin
                pop <= 1'b1;
                idle_left = pick_gap(calm);
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        logic [31:0] phase_base;
        sb = new();
        send_calm = 0;
        hold_pop = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Base just below the top of the address space so addresses wrap early.
        write_base(32'hFFFF_FFFA);
        foreach (DIRECTED[i])
            send_word(DIRECTED[i][15:0], DIRECTED[i][16], 1'b0);
        drain_and_settle();

        // No final word is forced at a phase end, so a new base may land mid-image.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: phase_base = 32'h0000_0000;
                1: phase_base = 32'hFFFF_FFFF;
                2: phase_base = $urandom;
                default: phase_base = 32'h7FFF_FFFE;
            endcase
            write_base(phase_base);
            if (phase == 1)
            begin
                hold_pop = 1'b1;
                repeat (24) send_word(rand_narrow(), 1'b0, 1'b1);
            end
            random_words(PHASE_WORDS);
            drain_and_settle();
        end

        sb.flush_missing();
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### thumb_instruction_predecoder.f
rtl/core/tipd_pkg.sv
rtl/core/tipd_front.sv
rtl/core/tipd_queue.sv
rtl/core/tipd_back.sv
rtl/core/thumb_instruction_predecoder.sv
sim/thumb_instruction_predecoder_tb.sv
